FILE: hdl/lru_cache_tracker_macros.svh
// ----------------------------------------------------------------------------
// lru_cache_tracker assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_TRACKER_MACROS_SVH
`define LRU_CACHE_TRACKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// shared types and constants of the lru cache tracker
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  // width of the key fields on the ports
  localparam int unsigned FIELD_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
    logic emit;
  } lct_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
  } lct_sts_t;

endpackage

`default_nettype wire

FILE: hdl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// sequencer: accept, compare, update, then emit the recency list
// ----------------------------------------------------------------------------
`default_nettype none

module lct_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output lct_pkg::lct_cmd_t cmd,
  input  lct_pkg::lct_sts_t sts
);
  import lct_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CMP;
      end
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.load    = start && (state_r == ST_IDLE);
  assign cmd.compare = (state_r == ST_CMP);
  assign cmd.update  = (state_r == ST_UPD);
  assign cmd.emit    = (state_r == ST_EMIT);

endmodule

`default_nettype wire

FILE: hdl/lct_datapath.sv
// ----------------------------------------------------------------------------
// lct_datapath
// recency stack, parallel key compare, shift update and rotating readout
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_cache_tracker_macros.svh"

module lct_datapath #(
  parameter int CAPACITY  = 4,
  parameter int KEY_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lct_pkg::lct_cmd_t                  cmd,
  output lct_pkg::lct_sts_t                  sts,
  input  logic signed [lct_pkg::FIELD_W-1:0] in_access_key,
  output logic                               out_valid,
  output logic signed [lct_pkg::FIELD_W-1:0] out_entry_key,
  output logic                               out_was_hit,
  output logic                               out_evicted_valid,
  output logic signed [lct_pkg::FIELD_W-1:0] out_evicted_key,
  output logic                               out_last_entry
);
  import lct_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] stack_r   [CAPACITY];
  logic [KEY_WIDTH-1:0] shift_src [CAPACITY];
  logic [KEY_WIDTH-1:0] rot_src   [CAPACITY];
  logic [CAPACITY-1:0]  shift_en;
  logic [CAPACITY-1:0]  rot_en;
  logic [CAPACITY-1:0]  match_nxt;
  logic [CAPACITY-1:0]  match_r;
  logic                 hit_r;
  logic                 full;
  logic [OCC_W-1:0]     occ_r;
  logic [OCC_W-1:0]     occ_upd;
  logic [OCC_W-1:0]     cnt_r;
  logic                 ev_valid_r;
  logic [KEY_WIDTH-1:0] ev_key_r;
  logic [FIELD_W-1:0]   head_field;
  logic [FIELD_W-1:0]   ev_field;

  // key width adaption on the way in and out
  generate
    if (KEY_WIDTH <= FIELD_W) begin : g_in_narrow
      assign key_in = in_access_key[KEY_WIDTH-1:0];
    end else begin : g_in_wide
      assign key_in = {{(KEY_WIDTH-FIELD_W){1'b0}}, in_access_key};
    end
    if (KEY_WIDTH >= FIELD_W) begin : g_out_wide
      assign head_field = stack_r[0][FIELD_W-1:0];
      assign ev_field   = ev_key_r[FIELD_W-1:0];
    end else begin : g_out_narrow
      assign head_field = {{(FIELD_W-KEY_WIDTH){1'b0}}, stack_r[0]};
      assign ev_field   = {{(FIELD_W-KEY_WIDTH){1'b0}}, ev_key_r};
    end
  endgenerate

  assign full    = (occ_r == OCC_W'(CAPACITY));
  assign occ_upd = (!hit_r && !full) ? occ_r + OCC_W'(1) : occ_r;
  assign sts.last = (cnt_r == OCC_W'(1));

  // per-entry compare, shift and rotate selection
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      assign match_nxt[i] = (OCC_W'(i) < occ_r) && (stack_r[i] == key_r);
      assign rot_en[i]    = (OCC_W'(i + 1) <= occ_r);
      if (i == 0) begin : g_head
        assign shift_src[i] = key_r;
        assign shift_en[i]  = 1'b1;
      end else begin : g_body
        assign shift_src[i] = stack_r[i-1];
        assign shift_en[i]  = !(|match_r[i-1:0]) && (hit_r || (OCC_W'(i) <= occ_r));
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign rot_src[i] = stack_r[0];
      end else begin : g_mid
        assign rot_src[i] = (OCC_W'(i + 1) == occ_r) ? stack_r[0] : stack_r[i+1];
      end

      always_ff @(posedge clk) begin
        if (cmd.update && shift_en[i]) begin
          stack_r[i] <= shift_src[i];
        end else if (cmd.emit && rot_en[i]) begin
          stack_r[i] <= rot_src[i];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) key_r <= key_in;
    if (cmd.update) ev_key_r <= stack_r[CAPACITY-1];
    if (cmd.emit) begin
      out_entry_key     <= head_field;
      out_was_hit       <= hit_r;
      out_evicted_valid <= ev_valid_r;
      out_evicted_key   <= ev_valid_r ? ev_field : '0;
      out_last_entry    <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      cnt_r      <= '0;
      match_r    <= '0;
      hit_r      <= 1'b0;
      ev_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.compare) begin
        match_r <= match_nxt;
        hit_r   <= |match_nxt;
      end
      if (cmd.update) begin
        occ_r      <= occ_upd;
        cnt_r      <= occ_upd;
        ev_valid_r <= !hit_r && full;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r - OCC_W'(1);
      end
    end
  end

  `LCT_ASSERT_SAME(a_keys_unique, 1'b1, $onehot0(match_r), "key held twice in recency stack")
  `LCT_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= OCC_W'(CAPACITY), "occupancy above capacity")
  `LCT_ASSERT_NEXT(a_miss_grows, cmd.update && !hit_r && !full, occ_r == $past(occ_r) + OCC_W'(1), "miss did not grow occupancy")
  `LCT_ASSERT_NEXT(a_evict_full, cmd.update && (hit_r || !full), !ev_valid_r, "eviction without a full miss")

endmodule

`default_nettype wire

FILE: hdl/lru_cache_tracker.sv
// ----------------------------------------------------------------------------
// lru_cache_tracker
// fully associative lru tracker, emits the recency list after every access
// ----------------------------------------------------------------------------
// an accepted access passes the compare and update states, then the emit state
//   registers one result per held key; a new access is taken only back in idle,
//   once the last held key has been read out
// results cannot be stalled: each one is shown for exactly one cycle
// reset (rst_n low, synchronous) empties the tracker; stack contents are
//   not cleared, entries past the occupancy are never read
`default_nettype none

module lru_cache_tracker #(
  parameter int CAPACITY  = 4,
  parameter int KEY_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transaction: accepted when start is high and busy is low
  input  logic                               start,
  output logic                               busy,
  input  logic signed [lct_pkg::FIELD_W-1:0] in_access_key,
  // result transaction: one per held key, most recent first
  output logic                               out_valid,
  output logic signed [lct_pkg::FIELD_W-1:0] out_entry_key,
  output logic                               out_was_hit,
  output logic                               out_evicted_valid,
  output logic signed [lct_pkg::FIELD_W-1:0] out_evicted_key,
  output logic                               out_last_entry
);
  import lct_pkg::*;

  // command and status between sequencer and datapath
  lct_cmd_t cmd;
  lct_sts_t sts;

  // sequencer: idle -> compare -> update -> emit (one entry per cycle)
  lct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // datapath: the compare runs over all entries at once, the update shifts
  // entries up to the hit position, and the readout rotates the stack so
  // the head register always carries the next key to report
  lct_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_access_key     (in_access_key),
    .out_valid         (out_valid),
    .out_entry_key     (out_entry_key),
    .out_was_hit       (out_was_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_last_entry    (out_last_entry)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru cache tracker: a queue-fed driver sends
// keys under random idle bursts, a reference predictor keeps its own
// recency stack, and a monitor checks every list entry field by field
// ----------------------------------------------------------------------------

module tb_top;

  // tracker geometry, matched to the instance below
  localparam int LRU_DEPTH = 4;
  localparam int KEY_W     = lct_pkg::FIELD_W;

  // cycles with no transaction on either side before the run is abandoned
  localparam int STALL_LIMIT  = 400;
  // settle time after the last expected entry
  localparam int DRAIN_CYCLES = 12;
  // random accesses after the directed part
  localparam int RANDOM_KEYS  = 450;
  // accesses at the end that are sent back to back
  localparam int QUIET_TAIL   = 60;
  // size of the pool of keys that random accesses keep coming back to
  localparam int HOT_KEYS     = 6;

  typedef logic signed [KEY_W-1:0] key_t;

  // one expected entry of a recency list readout
  typedef struct {
    key_t entry_key;
    logic was_hit;
    logic evicted_valid;
    key_t evicted_key;
    logic last_entry;
  } list_entry_t;

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  logic start         = 1'b0;
  key_t in_access_key = '0;

  logic busy;
  logic out_valid;
  key_t out_entry_key;
  logic out_was_hit;
  logic out_evicted_valid;
  key_t out_evicted_key;
  logic out_last_entry;

  // keys still to be sent, and list entries still to be seen
  key_t        key_stream[$];
  list_entry_t awaited_entries[$];

  // predictor copy of the tracker: most recent key at index 0
  key_t model_lru[LRU_DEPTH];
  int   lru_fill = 0;

  int err_count  = 0;
  int keys_sent  = 0;
  int stim_total = 0;

  lru_cache_tracker #(
    .CAPACITY (LRU_DEPTH),
    .KEY_WIDTH(KEY_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_access_key    (in_access_key),
    .out_valid        (out_valid),
    .out_entry_key    (out_entry_key),
    .out_was_hit      (out_was_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key  (out_evicted_key),
    .out_last_entry   (out_last_entry)
  );

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // reset held low at the start, released once and never raised again
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // predictor: look the key up, reorder the stack, queue the whole list
  // --------------------------------------------------------------------------
  function automatic void apply_access(key_t key);
    int          found;
    int          pos;
    int          i;
    logic        hit;
    logic        evict;
    key_t        gone;
    list_entry_t ent;
    found = -1;
    hit   = 1'b0;
    evict = 1'b0;
    gone  = '0;
    for (i = 0; i < lru_fill; i++) begin
      if (found < 0 && model_lru[i] == key) found = i;
    end
    if (found >= 0) begin
      // hit: pull the key forward, the ones above it slide down by one
      hit = 1'b1;
      pos = found;
    end else if (lru_fill == LRU_DEPTH) begin
      // miss while full: the least recent key drops out
      evict = 1'b1;
      gone  = model_lru[LRU_DEPTH-1];
      pos   = LRU_DEPTH - 1;
    end else begin
      // miss with room left: every held key moves down one place
      pos = lru_fill;
      lru_fill++;
    end
    for (i = pos; i > 0; i--) model_lru[i] = model_lru[i-1];
    model_lru[0] = key;
    for (i = 0; i < lru_fill; i++) begin
      ent.entry_key     = model_lru[i];
      ent.was_hit       = hit;
      ent.evicted_valid = evict;
      ent.evicted_key   = gone;
      ent.last_entry    = (i == lru_fill - 1);
      awaited_entries.push_back(ent);
    end
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: one key per transaction, random idle bursts between them
  // --------------------------------------------------------------------------
  int   gap_left = 0;
  logic idle_on  = 1'b1;

  always @(posedge clk) begin : drive_proc
    logic go;
    key_t sent;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        // transaction accepted at this edge
        sent = key_stream.pop_front();
        apply_access(sent);
        keys_sent++;
        go = 1'b0;
        // switch idling on or off now and then so some stretches run flat out
        if (keys_sent % 30 == 0) idle_on = ($urandom_range(0, 2) != 0);
        if (idle_on && keys_sent < stim_total - QUIET_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 9);
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_stream.size() > 0) begin
          go = 1'b1;
          in_access_key <= key_stream[0];
        end
      end
      start <= go;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobed entry is matched against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    list_entry_t want;
    if (rst_n && out_valid) begin
      if (awaited_entries.size() == 0) begin
        $display("%0t: unexpected entry, expected none, actual key %h", $time,
                 out_entry_key);
        err_count++;
      end else begin
        want = awaited_entries.pop_front();
        check_field("entry_key", want.entry_key, out_entry_key);
        check_field("was_hit", KEY_W'(want.was_hit), KEY_W'(out_was_hit));
        check_field("evicted_valid", KEY_W'(want.evicted_valid),
                    KEY_W'(out_evicted_valid));
        check_field("evicted_key", want.evicted_key, out_evicted_key);
        check_field("last_entry", KEY_W'(want.last_entry), KEY_W'(out_last_entry));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction ends the run
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    key_t hot[HOT_KEYS];
    key_t prev;
    key_t k;
    int   n;
    int   pick;

    // directed part: field extremes and the corner cases of the recency list
    key_stream.push_back(32'h8000_0000);  // first key into an empty tracker
    key_stream.push_back(32'h8000_0000);  // hit on the most recent key
    key_stream.push_back(32'h7fff_ffff);
    key_stream.push_back(32'h0000_0000);
    key_stream.push_back(32'hffff_ffff);  // tracker now full
    key_stream.push_back(32'h8000_0000);  // hit on the least recent key
    key_stream.push_back(32'h0000_0000);  // hit in the middle
    key_stream.push_back(32'h0000_0000);  // hit on the most recent key while full
    key_stream.push_back(32'h5555_5555);  // miss while full, eviction
    key_stream.push_back(32'haaaa_aaaa);  // eviction of all ones
    key_stream.push_back(32'h7fff_ffff);  // evicted key coming back
    key_stream.push_back(32'h0000_0001);
    key_stream.push_back(32'h0000_0001);
    key_stream.push_back(32'hffff_fffe);

    // random part: mostly a small pool of keys so hits and evictions mix
    for (n = 0; n < HOT_KEYS; n++) hot[n] = $urandom;
    prev = 32'h0000_0001;
    for (n = 0; n < RANDOM_KEYS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        k = $urandom;
      end else if (pick == 2) begin
        k = $urandom;
        hot[$urandom_range(0, HOT_KEYS - 1)] = k;
      end else if (pick == 3) begin
        k = prev;
      end else begin
        k = hot[$urandom_range(0, HOT_KEYS - 1)];
      end
      key_stream.push_back(k);
      prev = k;
    end
    stim_total = key_stream.size();

    // wait for every key to go out and every list entry to come back
    while (!rst_n) @(posedge clk);
    while (key_stream.size() > 0 || awaited_entries.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
